>>> hw/rtl/glbe_pkg.sv
// Shared constants and types for the graph labeling bandwidth evaluator.
`timescale 1ns / 1ps

package glbe_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int LABEL_W      = 7;
   localparam int ROW_W        = 64;
   localparam int CNT_W        = 7;
   localparam int COST_W       = 17;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam int REQ_FIELDS_W = LABEL_W + ROW_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((COST_W + 7) / 8) * 8;

   localparam logic [COST_W-1:0] INVALID_COST = COST_W'(100000);
   localparam logic [CNT_W-1:0]  CNT_ONE      = CNT_W'(1);

   // One accepted vertex, classified by the front end.
   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [LABEL_W-1:0] label;
      logic [IDX_W-1:0]   idx;
      logic               last;
      logic               ok;
   } entry_type;

   // What the back end keeps per vertex in its RAM.
   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [LABEL_W-1:0] label;
   } store_type;

endpackage

>>> hw/rtl/glbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module glbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/glbe_front.sv
// Front end: accepts vertices, checks labels, decides end of labeling and validity.
`timescale 1ns / 1ps

module glbe_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [glbe_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [glbe_pkg::CNT_W-1:0]          vertex_count_eff,
   output logic                                q_push,
   output glbe_pkg::entry_type                 q_wdata,
   input  logic                                q_full
);

   logic [glbe_pkg::MAX_VERTICES-1:0] used_ff, used_in, used_next, lab_bit, full_mask;
   logic                              bad_ff, bad_in, bad_next;
   logic [glbe_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [glbe_pkg::LABEL_W-1:0]      lab;
   logic [glbe_pkg::ROW_W-1:0]        row;
   logic [glbe_pkg::CNT_W-1:0]        cnt_next;
   logic                              lab_bad, dup, last, accept;

   assign lab = req_tdata[glbe_pkg::LABEL_W-1:0];
   assign row = req_tdata[glbe_pkg::LABEL_W +: glbe_pkg::ROW_W];

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      for (int k = 0; k < glbe_pkg::MAX_VERTICES; k++) begin
         lab_bit[k]   = (lab == glbe_pkg::LABEL_W'(k + 1));
         full_mask[k] = (glbe_pkg::CNT_W'(k) < vertex_count_eff);
      end
   end

   assign lab_bad   = (lab == '0) || (lab > glbe_pkg::LABEL_W'(glbe_pkg::MAX_VERTICES));
   assign dup       = |(used_ff & lab_bit);
   assign bad_next  = bad_ff || lab_bad || dup;
   assign used_next = used_ff | lab_bit;
   assign cnt_next  = glbe_pkg::CNT_W'(idx_ff) + glbe_pkg::CNT_ONE;
   assign last      = (cnt_next >= vertex_count_eff);

   always_comb begin
      q_push        = accept;
      q_wdata.row   = row;
      q_wdata.label = lab;
      q_wdata.idx   = idx_ff;
      q_wdata.last  = last;
      q_wdata.ok    = !bad_next && (used_next == full_mask);
   end

   always_comb begin
      used_in = used_ff;
      bad_in  = bad_ff;
      idx_in  = idx_ff;
      if (accept) begin
         if (last) begin
            used_in = '0;
            bad_in  = 1'b0;
            idx_in  = '0;
         end else begin
            used_in = used_next;
            bad_in  = bad_next;
            idx_in  = idx_ff + glbe_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         bad_ff  <= 1'b0;
         idx_ff  <= '0;
      end else begin
         used_ff <= used_in;
         bad_ff  <= bad_in;
         idx_ff  <= idx_in;
      end
   end

endmodule

>>> hw/rtl/glbe_fifo.sv
// Short queue of classified vertices between front and back end.
`timescale 1ns / 1ps

module glbe_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  glbe_pkg::entry_type  wdata,
   output logic                 full,
   input  logic                 pop,
   output glbe_pkg::entry_type  rdata,
   output logic                 not_empty
);

   glbe_pkg::entry_type                 slot_ff [glbe_pkg::QUEUE_DEPTH];
   logic [glbe_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [glbe_pkg::QPTR_W:0]           count_ff, count_in;

   assign full      = (count_ff == (glbe_pkg::QPTR_W + 1)'(glbe_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign rdata     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == glbe_pkg::QPTR_W'(glbe_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + glbe_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == glbe_pkg::QPTR_W'(glbe_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + glbe_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (glbe_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (glbe_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/glbe_back.sv
// Back end: scans earlier vertices from RAM, keeps the running maximum, emits results.
`timescale 1ns / 1ps

module glbe_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_not_empty,
   input  glbe_pkg::entry_type         q_rdata,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [glbe_pkg::COST_W-1:0] rsp_cost,
   output logic                        rsp_ok
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                          state_ff, state_in;
   glbe_pkg::entry_type           cur_ff;
   logic [glbe_pkg::IDX_W-1:0]    j_ff, j_in, rd_j_ff;
   logic                          rd_vld_ff;
   logic [glbe_pkg::LABEL_W-1:0]  max_ff, max_in, diff;
   logic                          rsp_valid_ff, rsp_valid_in, rsp_ok_ff;
   logic [glbe_pkg::COST_W-1:0]   rsp_cost_ff;
   glbe_pkg::store_type           rd_data, wr_data;
   logic                          rd_issue, scan_done, rsp_free, commit, edge_hit;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign q_pop     = (state_ff == ST_IDLE) && q_not_empty;
   assign rd_issue  = (state_ff == ST_SCAN) && (j_ff != cur_ff.idx);
   assign scan_done = (state_ff == ST_SCAN) && (j_ff == cur_ff.idx) && !rd_vld_ff;
   assign commit    = scan_done && (!cur_ff.last || rsp_free);

   assign wr_data.row   = cur_ff.row;
   assign wr_data.label = cur_ff.label;

   glbe_ram #(
      .WIDTH ($bits(glbe_pkg::store_type)),
      .DEPTH (glbe_pkg::MAX_VERTICES)
   ) u_store (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (cur_ff.idx),
      .wr_data (wr_data),
      .rd_en   (rd_issue),
      .rd_addr (j_ff),
      .rd_data (rd_data)
   );

   // edge in either direction between current vertex and stored vertex rd_j
   assign edge_hit = cur_ff.row[rd_j_ff] || rd_data.row[cur_ff.idx];
   assign diff     = (cur_ff.label > rd_data.label) ? cur_ff.label - rd_data.label
                                                    : rd_data.label - cur_ff.label;

   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               state_in = ST_SCAN;
               j_in     = '0;
            end
         end
         ST_SCAN: begin
            if (rd_issue) begin
               j_in = j_ff + glbe_pkg::IDX_W'(1);
            end
            if (rd_vld_ff && edge_hit && (diff > max_ff)) begin
               max_in = diff;
            end
            if (commit) begin
               state_in = ST_IDLE;
               if (cur_ff.last) begin
                  max_in       = '0;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_rdata;
      end
      rd_j_ff <= j_ff;
      if (commit && cur_ff.last) begin
         rsp_ok_ff   <= cur_ff.ok;
         rsp_cost_ff <= cur_ff.ok ? glbe_pkg::COST_W'(max_ff) : glbe_pkg::INVALID_COST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         j_ff         <= '0;
         rd_vld_ff    <= 1'b0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         rd_vld_ff    <= rd_issue;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cost  = rsp_cost_ff;
   assign rsp_ok    = rsp_ok_ff;

   // in-flight read always targets a vertex earlier than the current one
   a_rd_below_cur: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (rd_j_ff < cur_ff.idx))
      else $error("read in flight beyond current vertex");

   // a valid labeling uses labels 1..n, so its bandwidth stays below MAX_VERTICES
   a_valid_cost_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ok_ff) |-> (rsp_cost_ff < glbe_pkg::COST_W'(glbe_pkg::MAX_VERTICES)))
      else $error("valid result with out-of-range bandwidth");

   // after commit nothing of the finished vertex is still in flight
   a_commit_clean: assert property (@(posedge clock) disable iff (reset)
      commit |=> (state_ff == ST_IDLE) && !rd_vld_ff)
      else $error("read left in flight after commit");

endmodule

>>> hw/rtl/graph_labeling_bandwidth_eval.sv
// Top level of the graph labeling bandwidth evaluator.
`timescale 1ns / 1ps

// Scores one vertex labeling of a graph. Send one item per vertex in order
// (label and adjacency row); after vertex_count items one result item comes
// out: the bandwidth with valid_res=1, or cost 100000 with valid_res=0 when the
// labels are not a permutation of 1..n. A front end checks labels and queues
// vertices in a two-entry queue; a back end compares vertex i with the i
// earlier vertices held in a single-read-port RAM, one per cycle. It takes up
// a new vertex only once the last one is finished; the queue and the result
// register let the input and output sides stall independently.
// No clearing pass is needed after reset. Write vertex_count (0 acts as 1,
// above 64 acts as 64) only while the block is idle.

module graph_labeling_bandwidth_eval (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [6:0] label, [70:7] adjacency_row, [71] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [glbe_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // rsp_tdata: [16:0] cost, [23:17] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [glbe_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // rsp_tuser: [0] valid_res
   output logic                                rsp_tuser,
   // vertex_count register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [glbe_pkg::CNT_W-1:0]          csr_data
);

   logic [glbe_pkg::CNT_W-1:0]  vertex_count_ff, vertex_count_in, vertex_count_eff;
   logic                        q_push, q_pop, q_full, q_not_empty;
   glbe_pkg::entry_type         q_wdata, q_rdata;
   logic [glbe_pkg::COST_W-1:0] rsp_cost;

   assign csr_ready       = 1'b1;
   assign vertex_count_in = (csr_valid && csr_ready) ? csr_data : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= glbe_pkg::CNT_W'(glbe_pkg::MAX_VERTICES);
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   // clamp n into 1..MAX_VERTICES
   always_comb begin
      priority if (vertex_count_ff == '0) begin
         vertex_count_eff = glbe_pkg::CNT_ONE;
      end else if (vertex_count_ff > glbe_pkg::CNT_W'(glbe_pkg::MAX_VERTICES)) begin
         vertex_count_eff = glbe_pkg::CNT_W'(glbe_pkg::MAX_VERTICES);
      end else begin
         vertex_count_eff = vertex_count_ff;
      end
   end

   glbe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .vertex_count_eff (vertex_count_eff),
      .q_push           (q_push),
      .q_wdata          (q_wdata),
      .q_full           (q_full)
   );

   glbe_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .rdata     (q_rdata),
      .not_empty (q_not_empty)
   );

   glbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_rdata     (q_rdata),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_cost    (rsp_cost),
      .rsp_ok      (rsp_tuser)
   );

   assign rsp_tdata = {{(glbe_pkg::RSP_TDATA_W - glbe_pkg::COST_W){1'b0}}, rsp_cost};

endmodule

>>> sim/graph_labeling_bandwidth_eval_tb.sv
// Testbench for graph_labeling_bandwidth_eval: labelings in, bandwidth scores checked out.
`timescale 1ns / 1ps

// Feeds whole vertex labelings into the evaluator and checks every score it
// returns against an in-bench bandwidth predictor. Stimulus runs in phases:
// a directed part (label extremes, bad labels, self loops, edges past n,
// count register extremes, a count change partway through a labeling), a
// long receiver hold that backs the block up, then random labelings. Most
// random labelings are valid permutations with random edges; the rest carry
// damaged labels. The count register is only rewritten once everything
// expected has come back and the back end has had time to go quiet.

module graph_labeling_bandwidth_eval_tb;

   localparam int ITEMS_TARGET  = 1400;
   localparam int PHASE_ITEMS   = 110;
   localparam int SETTLE_CYCLES = 300;     // a few vertices' worth of back end work
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic [glbe_pkg::LABEL_W-1:0] label;
      logic [glbe_pkg::ROW_W-1:0]   row;
   } vertex_type;

   typedef struct packed {
      logic [glbe_pkg::COST_W-1:0] cost;
      logic                        ok;
   } score_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [glbe_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [glbe_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [glbe_pkg::CNT_W-1:0]       csr_data = '0;

   // Pending stimulus, filled by the sequence block, drained by the driver.
   vertex_type                 vertex_q[$];
   logic [glbe_pkg::CNT_W-1:0] count_q[$];
   score_type                  scores_due[$];

   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   int   send_idle_pct = 17;
   int   recv_idle_pct = 47;
   int   holds_asked = 0;
   int   holds_done = 0;
   int   hold_left = 0;
   int   items_queued = 0;
   int   error_count = 0;
   int   cycle_count = 0;

   // Predictor copy of the block's state.
   logic [glbe_pkg::CNT_W-1:0]   count_cfg = glbe_pkg::CNT_W'(64);
   logic [glbe_pkg::LABEL_W-1:0] lbl_mem[glbe_pkg::MAX_VERTICES];
   logic [glbe_pkg::ROW_W-1:0]   row_mem[glbe_pkg::MAX_VERTICES];
   logic [63:0]                  used_mask = '0;
   logic                         saw_bad_label = 1'b0;
   logic [6:0]                   widest_gap = '0;
   logic [6:0]                   vert_idx = '0;

   graph_labeling_bandwidth_eval dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Register value as the block sees it: 0 acts as 1, anything past 64 as 64.
   function automatic int effective_count(input logic [glbe_pkg::CNT_W-1:0] v);
      if (v == 0) return 1;
      if (v > glbe_pkg::MAX_VERTICES) return glbe_pkg::MAX_VERTICES;
      return int'(v);
   endfunction

   // Fold one vertex into the running bandwidth; returns 1 when the labeling
   // is complete and a score is due.
   function automatic bit score_vertex(input logic [glbe_pkg::LABEL_W-1:0] lab,
                                       input logic [glbe_pkg::ROW_W-1:0] row,
                                       output score_type res);
      int          i, n, j, d, other;
      logic [63:0] full_mask;
      i = int'(vert_idx) % 64;
      n = effective_count(count_cfg);
      res = '0;
      // edge in either direction between this vertex and an earlier one
      for (j = 0; j < i; j++) begin
         if (row[j] || row_mem[j][i]) begin
            other = int'(lbl_mem[j]);
            d = (int'(lab) > other) ? int'(lab) - other : other - int'(lab);
            if (d > int'(widest_gap)) widest_gap = 7'(d);
         end
      end
      // label 0, above 64, or seen before all spoil the labeling
      if (lab == 0 || lab > glbe_pkg::MAX_VERTICES) begin
         saw_bad_label = 1'b1;
      end else begin
         if (used_mask[lab - 1]) saw_bad_label = 1'b1;
         used_mask[lab - 1] = 1'b1;
      end
      lbl_mem[i] = lab;
      row_mem[i] = row;
      vert_idx = 7'(i + 1);
      if (int'(vert_idx) < n) return 1'b0;
      full_mask = (n >= 64) ? '1 : ((64'(1) << n) - 64'(1));
      res.ok = !saw_bad_label && used_mask == full_mask;
      res.cost = res.ok ? glbe_pkg::COST_W'(widest_gap) : glbe_pkg::INVALID_COST;
      used_mask = '0;
      saw_bad_label = 1'b0;
      widest_gap = '0;
      vert_idx = '0;
      return 1'b1;
   endfunction

   // Request and register drivers: everything changes on the falling edge.
   always @(negedge clock) begin : drive_inputs
      vertex_type nxt;
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (vertex_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = vertex_q.pop_front();
               req_tdata <= {{(glbe_pkg::REQ_TDATA_W - glbe_pkg::LABEL_W
                               - glbe_pkg::ROW_W){1'b0}}, nxt.row, nxt.label};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (!csr_valid || csr_taken) begin
            if (count_q.size() != 0) begin
               csr_data <= count_q.pop_front();
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: random back-pressure, plus long holds on request.
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (holds_done != holds_asked) begin
            holds_done = holds_done + 1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Rising edge: check returned scores first, then predict from new items.
   always @(posedge clock) begin : track
      score_type want;
      score_type got;
      if (!reset) begin
         req_taken <= req_tvalid && req_tready;
         csr_taken <= csr_valid && csr_ready;
         if (rsp_tvalid && rsp_tready) begin
            got.cost = rsp_tdata[glbe_pkg::COST_W-1:0];
            got.ok = rsp_tuser;
            if (scores_due.size() == 0) begin
               $display("%0t: unexpected score, cost %0d valid_res %0b",
                        $time, got.cost, got.ok);
               error_count = error_count + 1;
            end else begin
               want = scores_due.pop_front();
               if (got.cost !== want.cost) begin
                  $display("%0t: cost mismatch, expected %0d, got %0d",
                           $time, want.cost, got.cost);
                  error_count = error_count + 1;
               end
               if (got.ok !== want.ok) begin
                  $display("%0t: valid_res mismatch, expected %0b, got %0b",
                           $time, want.ok, got.ok);
                  error_count = error_count + 1;
               end
            end
         end
         if (csr_valid && csr_ready) count_cfg = csr_data;
         if (req_tvalid && req_tready) begin
            if (score_vertex(req_tdata[glbe_pkg::LABEL_W-1:0],
                             req_tdata[glbe_pkg::LABEL_W +: glbe_pkg::ROW_W], want))
               scores_due.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Wait until every item is in, every score is back, then let the back
   // end finish any vertex that produces no score.
   task automatic drain_all();
      do begin
         @(posedge clock);
         #2;
      end while (vertex_q.size() != 0 || count_q.size() != 0 || req_tvalid || csr_valid
                 || scores_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      #2;
   endtask

   task automatic write_count(input logic [glbe_pkg::CNT_W-1:0] v);
      drain_all();
      count_q.push_back(v);
      do begin
         @(posedge clock);
         #2;
      end while (count_q.size() != 0 || csr_valid);
   endtask

   task automatic queue_vertex(input logic [glbe_pkg::LABEL_W-1:0] lab,
                               input logic [glbe_pkg::ROW_W-1:0] row);
      vertex_type v;
      v.label = lab;
      v.row = row;
      vertex_q.push_back(v);
      items_queued = items_queued + 1;
   endtask

   // One labeling of n vertices: mostly a shuffled permutation, sometimes
   // with damaged labels, occasionally pure noise.
   task automatic queue_labeling(input int n);
      logic [glbe_pkg::LABEL_W-1:0] labs[glbe_pkg::MAX_VERTICES];
      logic [glbe_pkg::LABEL_W-1:0] t;
      logic [glbe_pkg::ROW_W-1:0]   row, low_mask;
      int                           k, a, kind, density;
      for (k = 0; k < n; k++) labs[k] = glbe_pkg::LABEL_W'(k + 1);
      for (k = n - 1; k > 0; k--) begin
         a = $urandom_range(k);
         t = labs[k];
         labs[k] = labs[a];
         labs[a] = t;
      end
      kind = $urandom_range(99);
      if (kind >= 95) begin
         for (k = 0; k < n; k++) labs[k] = glbe_pkg::LABEL_W'($urandom_range(127));
      end else if (kind >= 70) begin
         repeat ($urandom_range(1, 2)) begin
            a = $urandom_range(n - 1);
            case ($urandom_range(3))
               0: labs[a] = '0;
               1: labs[a] = glbe_pkg::LABEL_W'($urandom_range(65, 127));
               2: labs[a] = labs[$urandom_range(n - 1)];
               default: begin
                  labs[a] = (n < 64) ? glbe_pkg::LABEL_W'($urandom_range(n + 1, 64))
                                     : glbe_pkg::LABEL_W'($urandom_range(1, 64));
               end
            endcase
         end
      end
      low_mask = (n >= 64) ? '1 : ((64'(1) << n) - 64'(1));
      density = $urandom_range(3);
      for (k = 0; k < n; k++) begin
         case (density)
            0: row = (64'(1) << $urandom_range(n - 1)) | (64'(1) << $urandom_range(n - 1));
            1: row = {$urandom, $urandom};
            2: row = {$urandom, $urandom} & {$urandom, $urandom} & low_mask;
            default: row = $urandom_range(1) ? '1 : '0;
         endcase
         queue_vertex(labs[k], row);
      end
   endtask

   initial begin : sequence_main
      logic [glbe_pkg::CNT_W-1:0] cfg;
      int                         phase, start;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #2;

      // single vertex: self loop, label 0, label 127, above 64, above n
      write_count(glbe_pkg::CNT_W'(1));
      queue_vertex(7'd1, '1);
      queue_vertex(7'd0, '0);
      queue_vertex(7'd127, '1);
      queue_vertex(7'd65, 64'h8000_0000_0000_0001);
      queue_vertex(7'd2, '0);

      // zero count behaves as one
      write_count(glbe_pkg::CNT_W'(0));
      queue_vertex(7'd1, 64'h1);

      // forward and backward edges, plus an edge past the last vertex
      write_count(glbe_pkg::CNT_W'(3));
      queue_vertex(7'd3, 64'h2);
      queue_vertex(7'd1, 64'h0);
      queue_vertex(7'd2, 64'h8000_0000_0000_0001);
      // repeated label
      queue_vertex(7'd1, '1);
      queue_vertex(7'd1, '1);
      queue_vertex(7'd2, '1);

      // no edges at all
      write_count(glbe_pkg::CNT_W'(2));
      queue_vertex(7'd2, '0);
      queue_vertex(7'd1, '0);

      // count drops below the vertices already seen in this labeling
      write_count(glbe_pkg::CNT_W'(5));
      queue_vertex(7'd1, 64'h6);
      queue_vertex(7'd2, 64'h1);
      queue_vertex(7'd3, 64'h3);
      write_count(glbe_pkg::CNT_W'(2));
      queue_vertex(7'd4, 64'h7);

      // back-pressure: receiver holds off while one-vertex labelings pile up
      write_count(glbe_pkg::CNT_W'(1));
      send_idle_pct = 0;
      holds_asked = holds_asked + 1;
      repeat (24) queue_vertex(($urandom_range(4) == 0)
                               ? glbe_pkg::LABEL_W'($urandom_range(127))
                               : 7'd1, {$urandom, $urandom});
      drain_all();

      // random labelings; idling pattern follows progress through the run
      phase = 0;
      while (items_queued < ITEMS_TARGET) begin
         case (phase)
            0: cfg = glbe_pkg::CNT_W'(64);
            1: cfg = glbe_pkg::CNT_W'(127);
            2: cfg = glbe_pkg::CNT_W'(1);
            3: cfg = glbe_pkg::CNT_W'(65);
            4: cfg = glbe_pkg::CNT_W'(2);
            default: cfg = (phase % 5 == 0) ? glbe_pkg::CNT_W'($urandom_range(17, 64))
                                            : glbe_pkg::CNT_W'($urandom_range(3, 16));
         endcase
         write_count(cfg);
         if (items_queued < ITEMS_TARGET / 3) begin
            send_idle_pct = 17;
            recv_idle_pct = 47;
         end else if (items_queued < 2 * ITEMS_TARGET / 3) begin
            send_idle_pct = 47;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         start = items_queued;
         while (items_queued - start < PHASE_ITEMS) queue_labeling(effective_count(cfg));
         phase = phase + 1;
      end
      drain_all();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/glbe_pkg.sv
hw/rtl/glbe_ram.sv
hw/rtl/glbe_front.sv
hw/rtl/glbe_fifo.sv
hw/rtl/glbe_back.sv
hw/rtl/graph_labeling_bandwidth_eval.sv
sim/graph_labeling_bandwidth_eval_tb.sv
